// ----- rtl/hrd16_pkg.sv -----
package hrd16_pkg;

  // Result kinds carried on the kind field.
  typedef logic [1:0] kind_t;

  localparam kind_t KIND_LITERAL  = 2'd0;
  localparam kind_t KIND_FILL     = 2'd1;
  localparam kind_t KIND_END      = 2'd2;
  localparam kind_t KIND_OVERFLOW = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_MISSING_FLAG = 1'b0;
  localparam logic CFG_MAX_WORDS    = 1'b1;

  // Field widths fixed by the word format.
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned RUN_W   = 15;
  localparam int unsigned TALLY_W = 13;

  // Code word that ends a ray, and the literal-run marker bit.
  localparam logic [WORD_W-1:0] END_CODE = 16'h0001;
  localparam int unsigned LITERAL_BIT = 15;

  // Register reset values.
  localparam logic [WORD_W-1:0]  MISSING_FLAG_RESET = 16'h8000;
  localparam logic [TALLY_W-1:0] MAX_WORDS_RESET    = 13'd4096;

endpackage

// ----- rtl/hrd16_run_length_decoder.sv -----
// Channel   Direction  Handshake            Payload
// src       in         src_valid/src_stall  word, first
// res       out        res_valid/res_stall  kind, value, run_length, total_words, last_fill_len
// cfg       in         cfg_we               cfg_index, cfg_data
//
// Each accepted word is decoded in the cycle it is accepted, and its result, if any,
// appears in the result register on the next cycle: one word per cycle unless the
// source is stalled, with a single decode step between the ray state and the result register.
// A synchronous active-high reset clears the ray state and the result valid flag
// and restores the configuration registers to their defaults.
// The source side is stalled only while a result waits in the result register and
// the sink stalls it; otherwise a new transfer is taken every cycle.
module hrd16_run_length_decoder
  import hrd16_pkg::*;
#(
  parameter int unsigned MAX_GATES_PER_RAY = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  // Compressed word stream.
  input  logic                      src_valid,
  output logic                      src_stall,
  input  logic [WORD_W-1:0]         word,
  input  logic                      first,
  // Decoded results.
  output logic                      res_valid,
  input  logic                      res_stall,
  output kind_t                     kind,
  output logic signed [WORD_W-1:0]  value,
  output logic [RUN_W-1:0]          run_length,
  output logic [TALLY_W-1:0]        total_words,
  output logic [RUN_W-1:0]          last_fill_len,
  // Configuration writes.
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [WORD_W-1:0]         cfg_data
);

  // The sum of a tally and a run length needs one bit more than the run length.
  localparam int unsigned SUM_W = RUN_W + 1;
  localparam logic [SUM_W-1:0] GATE_CAP = SUM_W'(MAX_GATES_PER_RAY);

  // Configuration registers.
  logic [WORD_W-1:0]  missing_flag;
  logic [TALLY_W-1:0] max_words;

  // Ray state.
  logic               in_literals;
  logic [RUN_W-1:0]   literals_left;
  logic [TALLY_W-1:0] word_tally;
  logic               ray_stopped;
  logic [RUN_W-1:0]   last_empty_run;

  logic               in_literals_next;
  logic [RUN_W-1:0]   literals_left_next;
  logic [TALLY_W-1:0] word_tally_next;
  logic               ray_stopped_next;
  logic [RUN_W-1:0]   last_empty_run_next;

  // Result of the current word.
  logic               emit;
  kind_t              kind_next;
  logic [WORD_W-1:0]  value_next;
  logic [RUN_W-1:0]   run_length_next;

  // State as seen by the current word, after a new-ray clear.
  logic               cur_in_literals;
  logic [RUN_W-1:0]   cur_literals_left;
  logic [TALLY_W-1:0] cur_word_tally;
  logic               cur_ray_stopped;
  logic [RUN_W-1:0]   cur_last_empty_run;

  logic [RUN_W-1:0]   run_n;
  logic [SUM_W-1:0]   tally_sum;
  logic [SUM_W-1:0]   limit;
  logic               accept;

  // A held result blocks the source only while the sink is stalling it.
  assign src_stall = res_valid & res_stall;
  assign accept    = src_valid & ~src_stall;

  assign run_n     = word[RUN_W-1:0];
  assign tally_sum = SUM_W'(cur_word_tally) + SUM_W'(run_n);
  // The gate limit is the smaller of the register and the build-time cap.
  assign limit     = (SUM_W'(max_words) < GATE_CAP) ? SUM_W'(max_words) : GATE_CAP;

  always_comb begin
    // A first word starts a new ray even in the middle of a literal run.
    cur_in_literals    = first ? 1'b0 : in_literals;
    cur_literals_left  = first ? '0 : literals_left;
    cur_word_tally     = first ? '0 : word_tally;
    cur_ray_stopped    = first ? 1'b0 : ray_stopped;
    cur_last_empty_run = first ? '0 : last_empty_run;

    in_literals_next    = cur_in_literals;
    literals_left_next  = cur_literals_left;
    word_tally_next     = cur_word_tally;
    ray_stopped_next    = cur_ray_stopped;
    last_empty_run_next = cur_last_empty_run;

    emit            = 1'b0;
    kind_next       = KIND_LITERAL;
    value_next      = '0;
    run_length_next = '0;

    if (cur_ray_stopped) begin
      // Words after an end or overflow are dropped until the next ray.
      emit = 1'b0;
    end else if (cur_in_literals) begin
      emit               = 1'b1;
      kind_next          = KIND_LITERAL;
      value_next         = word;
      run_length_next    = RUN_W'(1);
      literals_left_next = cur_literals_left - RUN_W'(1);
      if (literals_left_next == '0) begin
        in_literals_next = 1'b0;
      end
    end else if (word == END_CODE) begin
      emit             = 1'b1;
      kind_next        = KIND_END;
      ray_stopped_next = 1'b1;
    end else if (tally_sum > limit) begin
      emit             = 1'b1;
      kind_next        = KIND_OVERFLOW;
      run_length_next  = run_n;
      ray_stopped_next = 1'b1;
    end else begin
      // The limit never exceeds the tally's range, so the sum fits.
      word_tally_next = tally_sum[TALLY_W-1:0];
      if (word[LITERAL_BIT]) begin
        // A data code: the literal words follow, no result for the code itself.
        last_empty_run_next = '0;
        if (run_n != '0) begin
          in_literals_next   = 1'b1;
          literals_left_next = run_n;
        end
      end else begin
        last_empty_run_next = run_n;
        emit                = 1'b1;
        kind_next           = KIND_FILL;
        value_next          = missing_flag;
        run_length_next     = run_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      missing_flag <= MISSING_FLAG_RESET;
      max_words    <= MAX_WORDS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MISSING_FLAG: missing_flag <= cfg_data;
        CFG_MAX_WORDS:    max_words    <= cfg_data[TALLY_W-1:0];
        default:          missing_flag <= missing_flag;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_literals    <= 1'b0;
      literals_left  <= '0;
      word_tally     <= '0;
      ray_stopped    <= 1'b0;
      last_empty_run <= '0;
    end else if (accept) begin
      in_literals    <= in_literals_next;
      literals_left  <= literals_left_next;
      word_tally     <= word_tally_next;
      ray_stopped    <= ray_stopped_next;
      last_empty_run <= last_empty_run_next;
    end
  end

  // Result register: loaded by a word that gives a result, emptied when the sink
  // takes the transfer. A load can only happen when the register is free or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      kind          <= kind_next;
      value         <= value_next;
      run_length    <= run_length_next;
      total_words   <= word_tally_next;
      last_fill_len <= last_empty_run_next;
    end
  end

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hrd16_pkg::*;

  // The gate cap handed to the decoder; the predictor uses the same value.
  localparam int unsigned GATE_CAP = 4096;

  // One decoded result as it appears on the result channel.
  typedef struct {
    kind_t              kind;
    logic [WORD_W-1:0]  value;
    logic [RUN_W-1:0]   run_length;
    logic [TALLY_W-1:0] total_words;
    logic [RUN_W-1:0]   last_fill_len;
  } gate_result_t;

  // The scoreboard keeps its own copy of the ray state and of the two registers.
  // Every accepted word is decoded here, and whatever result it causes is queued.
  // The result monitor then checks each transfer against the oldest queued entry.
  class gate_scoreboard;
    logic [WORD_W-1:0]  missing_flag;
    logic [TALLY_W-1:0] max_words;
    int unsigned        gate_cap;
    bit                 in_literals;
    logic [RUN_W-1:0]   literals_left;
    logic [TALLY_W-1:0] tally;
    bit                 stopped;
    logic [RUN_W-1:0]   last_fill;
    gate_result_t       expected_q[$];
    int unsigned        accepted_words;
    int unsigned        decoded_words;
    int unsigned        checked;
    int unsigned        errors;

    function new(int unsigned cap);
      gate_cap       = cap;
      missing_flag   = MISSING_FLAG_RESET;
      max_words      = MAX_WORDS_RESET;
      accepted_words = 0;
      decoded_words  = 0;
      checked        = 0;
      errors         = 0;
      clear_ray();
    endfunction

    function void clear_ray();
      in_literals   = 1'b0;
      literals_left = '0;
      tally         = '0;
      stopped       = 1'b0;
      last_fill     = '0;
    endfunction

    function void write_register(logic idx, logic [WORD_W-1:0] data);
      if (idx == CFG_MISSING_FLAG) begin
        missing_flag = data;
      end else begin
        max_words = data[TALLY_W-1:0];
      end
    endfunction

    function void queue_result(kind_t k, logic [WORD_W-1:0] v, logic [RUN_W-1:0] rl);
      gate_result_t r;
      r.kind          = k;
      r.value         = v;
      r.run_length    = rl;
      r.total_words   = tally;
      r.last_fill_len = last_fill;
      expected_q.push_back(r);
    endfunction

    function void note_word(logic [WORD_W-1:0] w, logic f);
      int unsigned n;
      int unsigned lim;
      accepted_words++;
      if (f) clear_ray();
      if (stopped) return;
      decoded_words++;
      if (in_literals) begin
        queue_result(KIND_LITERAL, w, 15'd1);
        literals_left = literals_left - 15'd1;
        if (literals_left == 0) in_literals = 1'b0;
        return;
      end
      if (w == END_CODE) begin
        stopped = 1'b1;
        queue_result(KIND_END, '0, '0);
        return;
      end
      n   = w[RUN_W-1:0];
      lim = (max_words < gate_cap) ? max_words : gate_cap;
      if (int'(tally) + n > lim) begin
        stopped = 1'b1;
        queue_result(KIND_OVERFLOW, '0, n[RUN_W-1:0]);
        return;
      end
      tally = tally + n[TALLY_W-1:0];
      if (w[LITERAL_BIT]) begin
        last_fill = '0;
        if (n != 0) begin
          in_literals   = 1'b1;
          literals_left = n[RUN_W-1:0];
        end
        return;
      end
      last_fill = n[RUN_W-1:0];
      queue_result(KIND_FILL, missing_flag, n[RUN_W-1:0]);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(kind_t k, logic [WORD_W-1:0] v, logic [RUN_W-1:0] rl,
                      logic [TALLY_W-1:0] tw, logic [RUN_W-1:0] lf);
      gate_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("result kind %0d with nothing expected", k));
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (k !== e.kind) report($sformatf("kind %0d, want %0d", k, e.kind));
      if (v !== e.value) report($sformatf("value %h, want %h", v, e.value));
      if (rl !== e.run_length)
        report($sformatf("run_length %0d, want %0d", rl, e.run_length));
      if (tw !== e.total_words)
        report($sformatf("total_words %0d, want %0d", tw, e.total_words));
      if (lf !== e.last_fill_len)
        report($sformatf("last_fill_len %0d, want %0d", lf, e.last_fill_len));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     src_valid = 1'b0;
  logic                     src_stall;
  logic [WORD_W-1:0]        word = '0;
  logic                     first = 1'b0;
  logic                     res_valid;
  logic                     res_stall = 1'b0;
  kind_t                    kind;
  logic signed [WORD_W-1:0] value;
  logic [RUN_W-1:0]         run_length;
  logic [TALLY_W-1:0]       total_words;
  logic [RUN_W-1:0]         last_fill_len;
  logic                     cfg_we = 1'b0;
  logic                     cfg_index = 1'b0;
  logic [WORD_W-1:0]        cfg_data = '0;

  gate_scoreboard sb = new(GATE_CAP);

  // When calm is set, neither side inserts gaps, which gives a long stretch of
  // back-to-back transfers on both channels.
  bit          calm = 1'b0;
  // Effective gate limit of the current setting, used to size random fill runs.
  int unsigned cap = GATE_CAP;
  int unsigned rays = 0;
  int unsigned settings = 1;

  hrd16_run_length_decoder #(
    .MAX_GATES_PER_RAY(GATE_CAP)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .src_valid     (src_valid),
    .src_stall     (src_stall),
    .word          (word),
    .first         (first),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .kind          (kind),
    .value         (value),
    .run_length    (run_length),
    .total_words   (total_words),
    .last_fill_len (last_fill_len),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Safety net: a correct run finishes far earlier than this.
  initial begin
    #2_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // The sink stalls at random, about 20 percent of the time, unless the run is calm.
  always @(posedge clk) begin
    res_stall <= !calm && ($urandom_range(0, 99) < 20);
  end

  // Both monitors sample at the clock edge, before any of this edge's updates land,
  // so they see exactly the values on which the transfer happened.
  always @(posedge clk) begin
    if (!rst && src_valid && !src_stall) sb.note_word(word, first);
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      sb.check_result(kind, value, run_length, total_words, last_fill_len);
    end
  end

  // Offers one word and returns right after the edge where it was transferred.
  // Random gaps come first, so the payload never changes while it is stalled.
  task automatic send_word(input logic [WORD_W-1:0] w, input logic f);
    while (!calm && $urandom_range(0, 99) < 20) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    word      <= w;
    first     <= f;
    @(posedge clk);
    while (src_stall) @(posedge clk);
  endtask

  // Lowers valid and waits until every queued result has come out. Words that
  // cause no result may still be in the pipe, so it keeps waiting after that.
  task automatic settle();
    src_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes both registers, the missing flag first; only called while idle.
  task automatic program_registers(input logic [WORD_W-1:0] flag,
                                   input logic [TALLY_W-1:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MISSING_FLAG;
    cfg_data  <= flag;
    @(posedge clk);
    sb.write_register(CFG_MISSING_FLAG, flag);
    cfg_index <= CFG_MAX_WORDS;
    cfg_data  <= {{(WORD_W-TALLY_W){1'b0}}, limit};
    @(posedge clk);
    sb.write_register(CFG_MAX_WORDS, {{(WORD_W-TALLY_W){1'b0}}, limit});
    cfg_we <= 1'b0;
    cap = (limit < GATE_CAP) ? limit : GATE_CAP;
    settings++;
  endtask

  // Literal gate values lean toward the corners now and then, the end code among them.
  function automatic logic [WORD_W-1:0] random_literal();
    case ($urandom_range(0, 15))
      0:       return 16'h0000;
      1:       return END_CODE;
      2:       return 16'h8000;
      3:       return 16'hFFFF;
      4:       return 16'h7FFF;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Sends one run: a code word and, for a short literal run, its literal words.
  // Most runs are well formed; some are oversized, and some are plain noise.
  // Returns 1 when the run was the end code.
  task automatic send_run(input logic f, output bit ended);
    int unsigned pick;
    int unsigned n;
    pick  = $urandom_range(0, 99);
    ended = 1'b0;
    if (pick < 40) begin
      n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      send_word(16'h8000 | n[WORD_W-1:0], f);
      repeat (n) send_word(random_literal(), 1'b0);
    end else if (pick < 72) begin
      n = $urandom_range(0, cap / 4 + 2);
      if (n == 1) n = 0;
      send_word(n[WORD_W-1:0] & 16'h7FFF, f);
    end else if (pick < 80) begin
      // Almost always past the limit, so it usually ends in an overflow.
      send_word({$urandom_range(0, 1) == 1, 15'($urandom_range(cap, 32767))}, f);
    end else if (pick < 88) begin
      send_word(16'($urandom_range(0, 16'hFFFF)), f | ($urandom_range(0, 9) == 0));
    end else begin
      send_word(END_CODE, f);
      ended = 1'b1;
    end
  endtask

  // One ray: a first word, a random number of runs, usually an end code, and
  // sometimes a few stray words after the runs, which the decoder must drop if the ray has ended.
  task automatic play_ray();
    int unsigned steps;
    bit          ended;
    rays++;
    send_run(1'b1, ended);
    steps = $urandom_range(1, 14);
    while (!ended && steps != 0) begin
      send_run(1'b0, ended);
      steps--;
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) send_word(16'($urandom_range(0, 16'hFFFF)), 1'b0);
    end
  endtask

  task automatic random_words(input int unsigned count);
    int unsigned target;
    target = sb.accepted_words + count;
    while (sb.accepted_words < target) play_ray();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, at the reset settings. No first word is sent at the start,
    // since the decoder must already be ready for a ray after reset.
    send_word(16'h0000, 1'b0);  // empty fill run
    send_word(16'h8000, 1'b0);  // empty data run, no result
    send_word(16'h8003, 1'b0);  // three literals follow
    send_word(16'h0000, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(END_CODE, 1'b0);  // the end code as a literal is just data
    send_word(16'h7FFF, 1'b0);  // longest fill run, past the limit
    send_word(16'h1234, 1'b0);  // dropped after the overflow
    send_word(END_CODE, 1'b0);  // dropped too
    send_word(16'h8002, 1'b1);  // new ray, two literals expected
    send_word(16'h5555, 1'b0);
    send_word(16'h0FFF, 1'b1);  // new ray in the middle of a literal run
    send_word(16'h8001, 1'b0);  // brings the tally exactly to the limit
    send_word(16'hAAAA, 1'b0);
    send_word(16'h0000, 1'b0);  // zero-length runs still fit at the limit
    send_word(16'h8000, 1'b0);
    send_word(16'h0002, 1'b0);  // two gates too many
    send_word(16'h1000, 1'b1);  // a fill run as long as the whole limit
    send_word(END_CODE, 1'b0);
    send_word(END_CODE, 1'b1);  // a ray that ends on its first word
    send_word(16'hFFFF, 1'b1);  // longest literal run, past the limit
    random_words(250);

    // A zero limit lets only zero-length runs through.
    settle();
    program_registers(16'h7FFF, 13'd0);
    send_word(16'h0000, 1'b1);
    send_word(16'h8000, 1'b0);
    send_word(16'h0002, 1'b0);
    send_word(16'h8001, 1'b1);
    random_words(150);

    // Full limit without any idling on either side.
    settle();
    calm = 1'b1;
    program_registers(16'($urandom_range(0, 16'hFFFF)), 13'd4096);
    random_words(300);
    settle();
    calm = 1'b0;

    program_registers(16'h8000, 13'd1);
    random_words(150);

    settle();
    program_registers(16'($urandom_range(0, 16'hFFFF)), 13'($urandom_range(16, 600)));
    random_words(300);

    settle();
    program_registers(16'($urandom_range(0, 16'hFFFF)), 13'($urandom_range(0, 4096)));
    random_words(300);

    settle();
    $display("Sent %0d words, %0d of them decoded, in %0d rays under %0d register settings.",
             sb.accepted_words, sb.decoded_words, rays, settings);
    $display("Checked %0d results, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
